// ===== rtl/wildcard_glob_matcher_assert.svh =====
// Assertion macros for the glob matcher checker.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define WGM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define WGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wgm_pkg.sv =====
// Shared types, codes and helpers of the glob matcher.
`default_nettype none
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 16;

    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_REPORT  = 2'd2;

    localparam logic [7:0] CH_WILD_RUN = 8'h2A;
    localparam logic [7:0] CH_WILD_ONE = 8'h3F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ch;
        logic       first;
    } t_item;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_result;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CH_CASE_OFS;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wgm_in_stage.sv =====
// Input register stage holding one transaction for the matcher core.
`default_nettype none
module wgm_in_stage
    import wgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_held,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;
    assign o_held  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wgm_nfa.sv =====
// Pattern store and active-position set with the per-byte update.
`default_nettype none
module wgm_nfa
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int NPOS  = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(NPOS);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LVLS  = LEN_W;

    logic [7:0]      r_pat [MAX_PATTERN];
    logic [LEN_W-1:0] r_len;
    logic            r_too;
    logic [NPOS-1:0] r_init;
    logic [NPOS-1:0] r_act;

    logic [LEN_W-1:0] n_len;
    logic            n_too;
    logic [NPOS-1:0] n_init;
    logic [NPOS-1:0] n_act;

    logic [7:0]      c;
    logic            c_star;
    logic            wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [NPOS-1:0] prop;
    logic [NPOS-1:0] step_set;
    logic [NPOS-1:0] star_pos;

    // Prefix scan: a set position spreads right across a run of stars.
    function automatic logic [NPOS-1:0] close_stars(input logic [NPOS-1:0] set,
                                                   input logic [NPOS-1:0] pr);
        logic [NPOS-1:0] g;
        logic [NPOS-1:0] p;
        logic [NPOS-1:0] gn;
        logic [NPOS-1:0] pn;
        g = set;
        p = pr;
        for (int l = 0; l < LVLS; l++) begin
            gn = g;
            pn = p;
            for (int j = 0; j < NPOS; j++) begin
                if (j >= (1 << l)) begin
                    gn[j] = g[j] | (p[j] & g[j - (1 << l)]);
                    pn[j] = p[j] & p[j - (1 << l)];
                end
            end
            g = gn;
            p = pn;
        end
        return g;
    endfunction

    assign c      = fold_case(i_item.ch);
    assign c_star = (c == CH_WILD_RUN);

    // Star flags of live positions; prop[j] lets position j-1 feed j.
    always_comb begin
        star_pos = '0;
        prop     = '0;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            star_pos[p]  = (LEN_W'(p) < r_len) && (r_pat[p] == CH_WILD_RUN);
            prop[p + 1]  = star_pos[p];
        end
    end

    // One text byte: stars hold their position, others advance on a match.
    always_comb begin
        step_set = '0;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (r_act[p] && (LEN_W'(p) < r_len)) begin
                if (r_pat[p] == CH_WILD_RUN) begin
                    step_set[p] = 1'b1;
                end else if (r_pat[p] == CH_WILD_ONE || r_pat[p] == c) begin
                    step_set[p + 1] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_len  = r_len;
        n_too  = r_too;
        n_init = r_init;
        n_act  = r_act;
        wr_en  = 1'b0;
        wr_idx = r_len[IDX_W-1:0];
        o_result.matched  = r_act[r_len] && !r_too;
        o_result.overflow = r_too;
        if (i_step) begin
            unique case (i_item.action)
                ACT_PATTERN: begin
                    if (i_item.first) begin
                        wr_en     = 1'b1;
                        wr_idx    = '0;
                        n_len     = LEN_W'(1);
                        n_too     = 1'b0;
                        n_init    = '0;
                        n_init[0] = 1'b1;
                        n_init[1] = c_star;
                    end else if (r_len < LEN_W'(MAX_PATTERN)) begin
                        wr_en  = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                        // Start closure grows only while the whole prefix is stars.
                        n_init[n_len] = r_init[r_len] && c_star;
                    end else begin
                        n_too = 1'b1;
                    end
                    n_act = n_init;
                end
                ACT_TEXT: begin
                    n_act = close_stars(step_set, prop);
                end
                ACT_REPORT: begin
                    n_act = r_init;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_too  <= 1'b0;
            r_init <= NPOS'(1);
            r_act  <= NPOS'(1);
        end else begin
            r_len  <= n_len;
            r_too  <= n_too;
            r_init <= n_init;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pat[wr_idx] <= c;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wgm_out_stage.sv =====
// Result register for the report channel.
`default_nettype none
module wgm_out_stage
    import wgm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// Top level of the case-insensitive glob matcher with '*' and '?'.
// A report passes the input register, then the result register, before its result is valid.
// Throughput: one transaction per cycle unless stalled; the set update is combinational.
// Input stalls only while a held report faces a full result register; every action waits then.
// Reset (synchronous, active low) empties the pattern, clears overflow, activates position 0.
// The pattern bytes themselves are not cleared; only stored positions are ever read.
`default_nettype none
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_first,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_matched,
    output logic            o_overflow
);

    t_item   in_item;
    t_item   held_item;
    logic    held;
    logic    advance;
    logic    out_free;
    t_result core_result;
    t_result out_result;

    assign in_item.action = i_action;
    assign in_item.ch     = i_ch;
    assign in_item.first  = i_first;

    // Advance the held transaction unless it is a report facing a full result register.
    assign advance = held && ((held_item.action != ACT_REPORT) || out_free);

    wgm_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_held    (held),
        .o_item    (held_item)
    );

    // Update the pattern and active set for the held transaction.
    wgm_nfa #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_nfa (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (held_item),
        .o_result (core_result)
    );

    // Capture a result only for a report that advances.
    wgm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && (held_item.action == ACT_REPORT)),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_matched  = out_result.matched;
    assign o_overflow = out_result.overflow;

endmodule
`default_nettype wire

// ===== rtl/wgm_checker.sv =====
// Port-level checker for the glob matcher, bound to the top level.
`default_nettype none
`include "wildcard_glob_matcher_assert.svh"
module wgm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_matched,
    input wire logic o_overflow
);

    `WGM_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_matched) && $stable(o_overflow), "result changed while stalled")
    `WGM_ASSERT_NOW(a_ovf_no_match, o_valid && o_overflow, !o_matched, "match reported with overflow")
    `WGM_ASSERT_NOW(a_stall_cause, !o_ready, o_valid && !i_ready, "input stalled without a blocked result")

endmodule

bind wildcard_glob_matcher wgm_checker u_checker (.*);
`default_nettype wire

// ===== bench/tb_wildcard_glob_matcher.sv =====
// Self-checking testbench for the glob matcher: predicts every report and scores the DUT.
module tb_wildcard_glob_matcher;
    import wgm_pkg::*;

    localparam int PAT_DEPTH    = MAX_PATTERN_DEF;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 400000;

    // Action code the block has no use for; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_B = "b";
    localparam logic [7:0] CH_LOW_C = "c";
    localparam logic [7:0] CH_LOW_Z = "z";
    localparam logic [7:0] CH_UP_B  = "B";

    // Scoreboard: keeps its own pattern and active-position set and queues
    // one predicted result per accepted report transaction.
    class glob_scoreboard;
        logic [7:0]       pat_bytes [PAT_DEPTH];
        int unsigned      pat_len;
        bit [PAT_DEPTH:0] live;
        bit               too_long;
        t_result          result_q [$];
        int               errors;
        int               n_items;
        int               n_reports;
        int               n_hits;
        int               n_overflows;

        function new();
            foreach (pat_bytes[i]) pat_bytes[i] = '0;
            pat_len     = 0;
            too_long    = 1'b0;
            live        = {{PAT_DEPTH{1'b0}}, 1'b1};
            errors      = 0;
            n_items     = 0;
            n_reports   = 0;
            n_hits      = 0;
            n_overflows = 0;
        endfunction

        function logic [7:0] lower(input logic [7:0] c);
            return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE_OFS : c;
        endfunction

        // A star position may match nothing, so activity leaks past it.
        function bit [PAT_DEPTH:0] close_stars(input bit [PAT_DEPTH:0] s);
            int p;
            for (p = 0; p < pat_len; p++) begin
                if (s[p] && pat_bytes[p] == CH_WILD_RUN) begin
                    s[p+1] = 1'b1;
                end
            end
            return s;
        endfunction

        function void note_item(input logic [1:0] act, input logic [7:0] raw,
                                input logic first);
            logic [7:0]       c;
            bit [PAT_DEPTH:0] cur;
            bit [PAT_DEPTH:0] nxt;
            t_result          r;
            int               p;
            c = lower(raw);
            n_items++;
            case (act)
                ACT_PATTERN: begin
                    if (first) begin
                        pat_len  = 0;
                        too_long = 1'b0;
                    end
                    if (pat_len < PAT_DEPTH) begin
                        pat_bytes[pat_len] = c;
                        pat_len++;
                    end else begin
                        too_long = 1'b1;
                    end
                    live = {{PAT_DEPTH{1'b0}}, 1'b1};
                end
                ACT_TEXT: begin
                    cur = close_stars(live);
                    nxt = '0;
                    for (p = 0; p < pat_len; p++) begin
                        if (cur[p]) begin
                            if (pat_bytes[p] == CH_WILD_RUN) begin
                                nxt[p] = 1'b1;
                            end else if (pat_bytes[p] == CH_WILD_ONE || pat_bytes[p] == c) begin
                                nxt[p+1] = 1'b1;
                            end
                        end
                    end
                    live = close_stars(nxt);
                end
                ACT_REPORT: begin
                    cur        = close_stars(live);
                    r.overflow = too_long;
                    r.matched  = !too_long && cur[pat_len];
                    result_q.push_back(r);
                    live = {{PAT_DEPTH{1'b0}}, 1'b1};
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic m, input logic o);
            t_result want;
            if (result_q.size() == 0) begin
                $display("%0t: result with nothing pending: matched=%b overflow=%b",
                         $time, m, o);
                errors++;
                return;
            end
            want = result_q.pop_front();
            n_reports++;
            if (want.matched) n_hits++;
            if (want.overflow) n_overflows++;
            if (m !== want.matched) begin
                $display("%0t: matched mismatch: expected %b actual %b",
                         $time, want.matched, m);
                errors++;
            end
            if (o !== want.overflow) begin
                $display("%0t: overflow mismatch: expected %b actual %b",
                         $time, want.overflow, o);
                errors++;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic [1:0] i_action = ACT_TEXT;
    logic [7:0] i_ch     = '0;
    logic       i_first  = 1'b0;
    logic       i_ready  = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_matched;
    logic       o_overflow;

    glob_scoreboard sb;

    // Sender bookkeeping: transactions handed over, current burst, and the
    // pattern as sent (raw bytes), used only to build matching texts.
    int         sent       = 0;
    int         burst_left = 0;
    logic [7:0] pat_q [$];

    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int rx_mode    = 0;
    int phase_left = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    wildcard_glob_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_ch       (i_ch),
        .i_first    (i_first),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_matched  (o_matched),
        .o_overflow (o_overflow)
    );

    // Sample both handshakes at the edge; inputs and outputs change only by
    // nonblocking assignment, so these reads see the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_item(i_action, i_ch, i_first);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_matched, o_overflow);
        end
    end

    // Receiver: always ready, coin-flip, or mostly stalled, switching mode
    // after a random stretch so stalls land on every phase of a report.
    always @(posedge i_clk) begin
        if (phase_left == 0) begin
            rx_mode    <= $urandom_range(0, 2);
            phase_left <= $urandom_range(20, 120);
        end else begin
            phase_left <= phase_left - 1;
        end
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hand one transaction to the block; return at the edge that accepts it.
    // Between bursts, drop valid for a random gap.
    task automatic send(input logic [1:0] act, input logic [7:0] c, input logic f);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_action <= act;
        i_ch     <= c;
        i_first  <= f;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // Hold off until every report sent so far has been answered.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.n_items != sent || sb.pending() != 0);
    endtask

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(0, 1)) begin
            return c - CH_CASE_OFS;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        case ($urandom_range(0, 11))
            0, 1, 2: return CH_LOW_A;
            3, 4:    return CH_LOW_B;
            5:       return CH_UPPER_A;
            6:       return CH_UP_B;
            7, 8:    return CH_WILD_RUN;
            9:       return CH_WILD_ONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 7))
            0, 1:    return flip_case(CH_LOW_A);
            2:       return flip_case(CH_LOW_B);
            3:       return flip_case(CH_LOW_C);
            4:       return CH_WILD_RUN;
            5:       return CH_WILD_ONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append pattern bytes; a fresh load sets first on its opening byte.
    task automatic load_pattern(input int len, input bit fresh);
        logic [7:0] c;
        if (fresh) pat_q.delete();
        for (int i = 0; i < len; i++) begin
            c = pick_pattern_char();
            send(ACT_PATTERN, c, fresh && i == 0);
            pat_q.push_back(c);
        end
    endtask

    // Build a text that fits the stored pattern, then damage it now and then
    // so that near misses get through as well.
    task automatic send_fitting_text();
        logic [7:0] txt [$];
        int         pos;
        foreach (pat_q[i]) begin
            if (i < PAT_DEPTH) begin
                if (pat_q[i] == CH_WILD_RUN) begin
                    repeat ($urandom_range(0, 3)) txt.push_back(pick_text_char());
                end else if (pat_q[i] == CH_WILD_ONE) begin
                    txt.push_back(pick_text_char());
                end else begin
                    txt.push_back(flip_case(pat_q[i]));
                end
            end
        end
        if ($urandom_range(0, 9) < 3) begin
            pos = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0:       if (txt.size() != 0) txt[pos] = pick_text_char();
                1:       if (txt.size() != 0) txt.delete(pos);
                default: txt.insert(pos, pick_text_char());
            endcase
        end
        foreach (txt[i]) send(ACT_TEXT, txt[i], 1'($urandom_range(0, 1)));
    endtask

    task automatic send_report();
        send(ACT_REPORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [7:0] c;
        int         rounds;
        int         roll;
        sb = new();
        rounds = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Empty pattern and empty text must match.
        send(ACT_REPORT, 8'hFF, 1'b1);
        // A zero byte is an ordinary text character; it misses the empty pattern.
        send(ACT_TEXT, 8'h00, 1'b1);
        send(ACT_REPORT, 8'h00, 1'b0);
        // The unused action must change nothing, first bit set or not.
        send(ACT_UNUSED, 8'hA5, 1'b1);
        // Fill the pattern store and push one byte past it: overflow report.
        for (int i = 0; i <= PAT_DEPTH; i++) begin
            case (i)
                0:       c = CH_WILD_RUN;
                1:       c = CH_WILD_ONE;
                2:       c = 8'h00;
                3:       c = 8'hFF;
                4:       c = CH_UPPER_A;
                5:       c = CH_UPPER_Z;
                default: c = 8'(8'h60 + i);
            endcase
            send(ACT_PATTERN, c, i == 0);
        end
        send(ACT_REPORT, 8'h5A, 1'b0);
        // An all-star pattern matches the empty text; first clears overflow.
        send(ACT_PATTERN, CH_WILD_RUN, 1'b1);
        send(ACT_PATTERN, CH_WILD_RUN, 1'b0);
        send(ACT_REPORT, 8'h01, 1'b1);
        // Text '*' is literal but '?' takes it; upper-case pattern meets lower text.
        send(ACT_PATTERN, CH_WILD_ONE, 1'b1);
        send(ACT_PATTERN, CH_UPPER_Z, 1'b0);
        send(ACT_TEXT, CH_WILD_RUN, 1'b0);
        send(ACT_TEXT, CH_LOW_Z, 1'b1);
        send(ACT_REPORT, 8'h80, 1'b0);
        pat_q = '{CH_WILD_ONE, CH_UPPER_Z};
        drain();

        // Random part: rounds of texts and reports, some led by a pattern load,
        // salted with pattern bytes mid-text, noise texts and unused actions.
        while (sent < RANDOM_ITEMS + 30) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                case ($urandom_range(0, 19))
                    0:       load_pattern($urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 4), 1'b1);
                    1, 2, 3: load_pattern($urandom_range(9, PAT_DEPTH), 1'b1);
                    default: load_pattern($urandom_range(1, 6), 1'b1);
                endcase
            end else if (roll < 35) begin
                load_pattern($urandom_range(1, 4), 1'b0);
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(0, 5)) begin
                        send(ACT_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                end else begin
                    send_fitting_text();
                end
                if ($urandom_range(0, 19) == 0) load_pattern(1, 1'b0);
                if ($urandom_range(0, 29) == 0) begin
                    send(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                send_report();
            end
            rounds++;
            if (rounds % 100 == 0) drain();
        end

        // Wind down: wait for every result, then let the clock run on idle.
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.n_items != sent || sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d transactions, %0d reports checked (%0d matches, %0d overflows)",
                 sent, sb.n_reports, sb.n_hits, sb.n_overflows);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

endmodule
